// File: sv/u8u16_pkg.sv
// Package: shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8u16_pkg;

  // Byte class masks and patterns
  localparam logic [7:0] ByteAsciiLimit = 8'h80;
  localparam logic [7:0] LeadTwoMask    = 8'hE0;
  localparam logic [7:0] LeadTwoPat     = 8'hC0;
  localparam logic [7:0] LeadThreeMask  = 8'hF0;
  localparam logic [7:0] LeadThreePat   = 8'hE0;
  localparam logic [7:0] LowFiveMask    = 8'h1F;
  localparam logic [7:0] LowSixMask     = 8'h3F;
  localparam logic [7:0] LowFourMask    = 8'h0F;

  // Output queue depth
  localparam int unsigned OutDepth = 4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_end;
    logic        run_last;
  } result_t;

endpackage
`default_nettype wire

// File: sv/u8u16_in_if.sv
// Interface: byte input channel of the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface
`default_nettype wire

// File: sv/u8u16_out_if.sv
// Interface: code unit output channel of the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_end;
  logic        run_last;

  modport source (output valid, output code_unit, output string_end, output run_last,
                  input ready);
  modport sink (input valid, input code_unit, input string_end, input run_last,
                output ready);
endinterface
`default_nettype wire

// File: sv/utf8_to_utf16_decoder_top.sv
// Top level: streaming modified UTF-8 to UTF-16 decoder with a small result queue.
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte per cycle while its input is ready and emits 16-bit code units. Each
// byte is decoded in the cycle it is accepted, against the held lead and second byte,
// and its zero, one or two results are written into a four-entry result queue;
// results leave at one per cycle while the sink is ready, in the order queued. The
// input is ready while at most two queue entries are occupied, so a byte stream runs
// at one byte per cycle while the sink takes results; only a three-byte lead cut
// short by the end of the string yields two results from one byte. Bytes that follow
// a lead are not checked to be continuation bytes; stray bytes, 0xF0 and above, and
// leads at the end of a string come out as raw byte values.
module utf8_to_utf16_decoder_top #(
  parameter int unsigned Depth = u8u16_pkg::OutDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  u8u16_in_if.sink    in_i,
  u8u16_out_if.source out_o
);
  import u8u16_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  localparam logic [1:0] PhIdle     = 2'd0;
  localparam logic [1:0] PhTwo      = 2'd1;
  localparam logic [1:0] PhThree    = 2'd2;
  localparam logic [1:0] PhThreeSec = 2'd3;

  logic [1:0]    phase_q, phase_d;
  logic [7:0]    lead_q, lead_d;
  logic [7:0]    second_q, second_d;

  result_t       queue_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  logic          in_acc, out_acc;
  logic [1:0]    n_push;
  result_t       res0, res1;
  logic [7:0]    b;
  logic          fin;

  assign b        = in_i.in_byte;
  assign fin      = in_i.final_byte;
  assign in_i.ready = (count_q <= CntW'(Depth - 2));
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;

  // Decode the accepted byte against the held state
  always_comb begin
    phase_d  = phase_q;
    lead_d   = lead_q;
    second_d = second_q;
    n_push   = 2'd0;
    res0     = '{code_unit: {8'h00, b}, string_end: fin, run_last: 1'b1};
    res1     = '{code_unit: {8'h00, b}, string_end: fin, run_last: 1'b1};
    if (in_acc) begin
      case (phase_q)
        PhTwo: begin
          res0.code_unit = {5'd0, lead_q[4:0] & LowFiveMask[4:0], b[5:0] & LowSixMask[5:0]};
          n_push  = 2'd1;
          phase_d = PhIdle;
        end
        PhThree: begin
          if (fin) begin
            // lead cut short: emit lead raw, then this byte raw
            res0    = '{code_unit: {8'h00, lead_q}, string_end: 1'b0, run_last: 1'b0};
            n_push  = 2'd2;
            phase_d = PhIdle;
          end else begin
            second_d = b;
            phase_d  = PhThreeSec;
          end
        end
        PhThreeSec: begin
          res0.code_unit = {lead_q[3:0] & LowFourMask[3:0],
                            second_q[5:0] & LowSixMask[5:0],
                            b[5:0] & LowSixMask[5:0]};
          n_push  = 2'd1;
          phase_d = PhIdle;
        end
        default: begin
          if ((b >= ByteAsciiLimit) && !fin && ((b & LeadTwoMask) == LeadTwoPat)) begin
            lead_d  = b;
            phase_d = PhTwo;
          end else if ((b >= ByteAsciiLimit) && !fin &&
                       ((b & LeadThreeMask) == LeadThreePat)) begin
            lead_d  = b;
            phase_d = PhThree;
          end else begin
            n_push  = 2'd1;
            phase_d = PhIdle;
          end
        end
      endcase
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(out_acc);
    count_d  = count_q + CntW'(n_push) - CntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      lead_q   <= 8'h00;
      second_q <= 8'h00;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      lead_q   <= lead_d;
      second_q <= second_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  assign out_o.valid      = (count_q != '0);
  assign out_o.code_unit  = queue_q[rd_ptr_q].code_unit;
  assign out_o.string_end = queue_q[rd_ptr_q].string_end;
  assign out_o.run_last   = queue_q[rd_ptr_q].run_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (count_q + CntW'(2) <= CntW'(Depth)))
    else $error("input ready without room for two results");

  a_ascii_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PhIdle && !in_i.in_byte[7]) |=> out_o.valid)
    else $error("plain byte produced no result");

  a_two_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (phase_q == PhTwo || phase_q == PhThreeSec)) |=> (phase_q == PhIdle))
    else $error("completed sequence left state pending");
`endif

endmodule
`default_nettype wire

// File: bench/u8u16_unit_monitor.sv
// Monitor for the UTF-8 to UTF-16 decoder: predicts code units per byte and compares them.
`timescale 1ns / 1ps
module u8u16_unit_monitor (
  input  logic  clk_i,
  input  logic  rst_ni,
  u8u16_in_if   byte_if,
  u8u16_out_if  unit_if,
  output int    fail_count_o,
  output int    pending_o,
  output int    byte_count_o,
  output int    unit_count_o
);
  import u8u16_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhTwoLead,
    PhThreeLead,
    PhThreeSecond
  } decode_phase_e;

  decode_phase_e phase;
  logic [7:0]    held_lead;
  logic [7:0]    held_second;
  result_t       expected_units[$];

  function automatic void queue_unit(input logic [15:0] unit, input logic str_end,
                                     input logic last);
    result_t r;
    r.code_unit  = unit;
    r.string_end = str_end;
    r.run_last   = last;
    expected_units.push_back(r);
  endfunction

  // Advance the decode state by one byte and queue the units it completes.
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic [15:0] unit;
    unit = 16'h0000;
    case (phase)
      PhTwoLead: begin
        unit  = (16'(held_lead & LowFiveMask) << 6) | 16'(b & LowSixMask);
        phase = PhIdle;
        queue_unit(unit, fin, 1'b1);
      end
      PhThreeLead: begin
        if (fin) begin
          // lead cut short: emit both bytes raw
          phase = PhIdle;
          queue_unit(16'(held_lead), 1'b0, 1'b0);
          queue_unit(16'(b), 1'b1, 1'b1);
        end else begin
          held_second = b;
          phase       = PhThreeSecond;
        end
      end
      PhThreeSecond: begin
        unit  = (16'(held_lead & LowFourMask) << 12) | (16'(held_second & LowSixMask) << 6)
              | 16'(b & LowSixMask);
        phase = PhIdle;
        queue_unit(unit, fin, 1'b1);
      end
      default: begin
        if (b >= ByteAsciiLimit && !fin && (b & LeadTwoMask) == LeadTwoPat) begin
          held_lead = b;
          phase     = PhTwoLead;
        end else if (b >= ByteAsciiLimit && !fin && (b & LeadThreeMask) == LeadThreePat) begin
          held_lead = b;
          phase     = PhThreeLead;
        end else begin
          phase = PhIdle;
          queue_unit(16'(b), fin, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      phase        = PhIdle;
      held_lead    = 8'h00;
      held_second  = 8'h00;
      expected_units.delete();
      fail_count_o = 0;
      pending_o    = 0;
      byte_count_o = 0;
      unit_count_o = 0;
    end else begin
      if (unit_if.valid && unit_if.ready) begin
        unit_count_o++;
        if (expected_units.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected code unit %h end %b last %b", $realtime,
                     unit_if.code_unit, unit_if.string_end, unit_if.run_last);
        end else begin
          want = expected_units.pop_front();
          if (unit_if.code_unit !== want.code_unit || unit_if.string_end !== want.string_end
              || unit_if.run_last !== want.run_last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected unit %h end %b last %b, got %h end %b last %b",
                       $realtime, want.code_unit, want.string_end, want.run_last,
                       unit_if.code_unit, unit_if.string_end, unit_if.run_last);
          end
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        byte_count_o++;
        decode_byte(byte_if.in_byte, byte_if.final_byte);
      end
      pending_o = expected_units.size();
    end
  end

endmodule

// File: bench/tb_utf8_to_utf16_decoder_top.sv
// Testbench top for the UTF-8 to UTF-16 decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_utf8_to_utf16_decoder_top;

  localparam int CycleLimit  = 200000;
  localparam int RandomBytes = 400;
  localparam int CalmAfter   = 320;

  logic clk;
  logic rst_n;
  logic idle_on;
  int   random_sent;
  int   cycle_count;
  int   fail_count;
  int   pending;
  int   byte_count;
  int   unit_count;

  u8u16_in_if  byte_ch ();
  u8u16_out_if unit_ch ();

  utf8_to_utf16_decoder_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (unit_ch)
  );

  u8u16_unit_monitor unit_mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_if      (byte_ch),
    .unit_if      (unit_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .byte_count_o (byte_count),
    .unit_count_o (unit_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  // Sink side: stall in short random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    unit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        unit_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        unit_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        unit_ch.ready <= 1'b0;
      end else begin
        unit_ch.ready <= 1'b1;
      end
    end
  end

  // Present one byte, optionally after an idle burst, and hold it until taken.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.in_byte    <= b;
    byte_ch.final_byte <= fin;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // Build one string of mostly well-formed characters with some noise and broken leads.
  task automatic send_random_string();
    logic [7:0] str_bytes[$];
    int         nchars;
    int         kind;
    nchars = $urandom_range(1, 6);
    for (int c = 0; c < nchars; c++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: str_bytes.push_back(8'($urandom_range(0, 127)));
        4, 5: begin
          str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        6, 7: begin
          str_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
          str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        8: str_bytes.push_back(8'($urandom_range(0, 255)));
        default: begin
          // truncated lead: the next character or the string end cuts it off
          if ($urandom_range(0, 1) == 0) begin
            str_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          end else begin
            str_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            str_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    foreach (str_bytes[i]) begin
      push_byte(str_bytes[i], i == str_bytes.size() - 1);
      random_sent++;
      if (random_sent >= CalmAfter) idle_on = 1'b0;
    end
  endtask

  initial begin
    idle_on     = 1'b1;
    random_sent = 0;
    rst_n              <= 1'b0;
    byte_ch.valid      <= 1'b0;
    byte_ch.in_byte    <= 8'h00;
    byte_ch.final_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ASCII extremes and stray bytes
    push_byte(8'h00, 1'b0); push_byte(8'h7F, 1'b1);
    push_byte(8'h80, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'hFF, 1'b1);
    // two-byte forms, second byte not a continuation byte too
    push_byte(8'hC0, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hDF, 1'b0); push_byte(8'hFF, 1'b1);
    // three-byte forms
    push_byte(8'hE0, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
    // leads at string end, then a three-byte lead cut short, then a new string
    push_byte(8'hC5, 1'b1); push_byte(8'hEA, 1'b1);
    push_byte(8'hE3, 1'b0); push_byte(8'h9A, 1'b1);
    push_byte(8'h41, 1'b1);

    while (random_sent < RandomBytes) send_random_string();
    byte_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Decoded %0d bytes into %0d code units: ASCII, two- and three-byte forms,",
             byte_count, unit_count);
    $display("stray bytes, truncated leads and back-pressure on both sides.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
